// File: rtl/gac_pkg.sv
// Shared definitions for the gamma alpha compositor.
// Holds the request kind codes, the channel count and the default datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gac_pkg;

  // Default linear value width (Q0.n) and encode table index width
  localparam int LIN_BITS_DEF       = 16;
  localparam int ENC_INDEX_BITS_DEF = 12;

  // Number of color channels handled side by side
  localparam int NUM_CH = 3;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_FG_WR  = 2'd0,
    KIND_BG_WR  = 2'd1,
    KIND_ENC_WR = 2'd2,
    KIND_PIXEL  = 2'd3
  } kind_t;

endpackage

`default_nettype wire

// File: rtl/gac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gamma_alpha_compositor.sv
// Gamma alpha compositor: six-stage pipeline (six register stages, two of them
// RAM reads), one request per cycle while the output is not stalled.
// Throughput: one request per cycle unless the output stalls; stages advance
// independently, so bubbles collapse and input is taken while a result waits
// if any stage is empty.
// Reset clears the stage valid bits only; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module gamma_alpha_compositor #(
  parameter int LIN_BITS       = gac_pkg::LIN_BITS_DEF,
  parameter int ENC_INDEX_BITS = gac_pkg::ENC_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [11:0] table_index,
  input  logic [15:0] table_value,
  input  logic [7:0]  fg_red,
  input  logic [7:0]  fg_green,
  input  logic [7:0]  fg_blue,
  input  logic [7:0]  fg_alpha,
  input  logic [7:0]  bg_red,
  input  logic [7:0]  bg_green,
  input  logic [7:0]  bg_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  import gac_pkg::*;

  localparam int NSTG     = 6;
  localparam int LIN      = LIN_BITS;
  localparam int ENC      = ENC_INDEX_BITS;
  localparam int PROD_W   = LIN + 8;
  // (2^LIN-1)*255 + 127 stays below 2^(LIN+8)
  localparam int SUM_W    = LIN + 8;
  // Reciprocal of 255 scaled so the quotient estimate is off by at most one
  localparam int SH       = SUM_W + 8;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int RPROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'd255;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // Sideband that travels with each request
  typedef struct packed {
    logic                  pix;
    logic                  transp;
    logic [NUM_CH-1:0][7:0] bg;
    logic                  enc_we;
    logic [ENC-1:0]        enc_idx;
    logic [7:0]            enc_val;
  } side_t;

  logic [NSTG:1] vld;
  logic [NSTG:1] en;
  side_t         side [1:NSTG];
  side_t         in_side;
  logic [7:0]    alpha1;

  logic          fg_we;
  logic          bg_we;
  logic          enc_we_in;
  logic          is_pix;
  logic [31:0]   tval_ext;
  logic [31:0]   tidx_ext;
  logic [LIN-1:0] dec_wdata;

  logic [7:0]        fg_ch  [NUM_CH];
  logic [7:0]        bg_ch  [NUM_CH];
  logic [LIN-1:0]    lf1    [NUM_CH];
  logic [LIN-1:0]    lb1    [NUM_CH];
  logic [PROD_W-1:0] pf2    [NUM_CH];
  logic [PROD_W-1:0] pb2    [NUM_CH];
  logic [SUM_W-1:0]  sum3   [NUM_CH];
  logic [SUM_W-1:0]  sum4   [NUM_CH];
  logic [LIN-1:0]    q4     [NUM_CH];
  logic [LIN-1:0]    lin5   [NUM_CH];
  logic [ENC-1:0]    eidx5  [NUM_CH];
  logic [7:0]        enc6   [NUM_CH];

  // Decode the request kind
  always_comb begin
    fg_we     = 1'b0;
    bg_we     = 1'b0;
    enc_we_in = 1'b0;
    is_pix    = 1'b0;
    unique case (kind_t'(kind))
      KIND_FG_WR:  fg_we     = 1'b1;
      KIND_BG_WR:  bg_we     = 1'b1;
      KIND_ENC_WR: enc_we_in = 1'b1;
      KIND_PIXEL:  is_pix    = 1'b1;
      default:     is_pix    = 1'b0;
    endcase
  end

  // Fit table data and address to the configured widths
  assign tval_ext  = {16'h0000, table_value};
  assign tidx_ext  = {20'h00000, table_index};
  assign dec_wdata = tval_ext[LIN-1:0];

  always_comb begin
    in_side.pix     = is_pix;
    in_side.transp  = (fg_alpha == 8'd0);
    in_side.bg[0]   = bg_red;
    in_side.bg[1]   = bg_green;
    in_side.bg[2]   = bg_blue;
    in_side.enc_we  = enc_we_in;
    in_side.enc_idx = tidx_ext[ENC-1:0];
    in_side.enc_val = table_value[7:0];
  end

  assign fg_ch[0] = fg_red;
  assign fg_ch[1] = fg_green;
  assign fg_ch[2] = fg_blue;
  assign bg_ch[0] = bg_red;
  assign bg_ch[1] = bg_green;
  assign bg_ch[2] = bg_blue;

  // Stage enables: a stage advances when empty or when the next one advances
  assign out_valid = vld[NSTG] && side[NSTG].pix;
  always_comb begin
    en[NSTG] = !out_valid || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end
  assign in_ready = en[1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Advance sideband
  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1] <= in_side;
      alpha1  <= fg_alpha;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Per-channel datapath
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [SUM_W:0]   sum_full;
    logic [RPROD_W-1:0] rprod;
    logic [SUM_W:0]   rem;
    logic             bump;
    logic [LIN:0]     q_fix;

    // Decode tables, read as the request is accepted
    gac_ram #(.WIDTH(LIN), .DEPTH(256)) u_fg_dec (
      .clk   (clk),
      .we    (in_valid && in_ready && fg_we),
      .waddr (table_index[7:0]),
      .wdata (dec_wdata),
      .re    (en[1]),
      .raddr (fg_ch[c]),
      .rdata (lf1[c])
    );

    gac_ram #(.WIDTH(LIN), .DEPTH(256)) u_bg_dec (
      .clk   (clk),
      .we    (in_valid && in_ready && bg_we),
      .waddr (table_index[7:0]),
      .wdata (dec_wdata),
      .re    (en[1]),
      .raddr (bg_ch[c]),
      .rdata (lb1[c])
    );

    // Weight foreground and background; drop the background when opaque
    always_ff @(posedge clk) begin
      if (en[2]) begin
        pf2[c] <= PROD_W'(lf1[c]) * PROD_W'(alpha1);
        pb2[c] <= (alpha1 == 8'd255) ? '0
                : PROD_W'(lb1[c]) * PROD_W'(8'd255 - alpha1);
      end
    end

    // Sum with rounding offset
    assign sum_full = (SUM_W+1)'(pf2[c]) + (SUM_W+1)'(pb2[c]) + (SUM_W+1)'(127);
    always_ff @(posedge clk) begin
      if (en[3]) begin
        sum3[c] <= sum_full[SUM_W-1:0];
      end
    end

    // Estimate sum / 255 by reciprocal multiply
    assign rprod = RPROD_W'(sum3[c]) * RPROD_W'(RECIP);
    always_ff @(posedge clk) begin
      if (en[4]) begin
        q4[c]   <= rprod[SH +: LIN];
        sum4[c] <= sum3[c];
      end
    end

    // Correct the estimate by one where the remainder reaches 255; saturate
    assign rem   = (SUM_W+1)'(sum4[c]) + (SUM_W+1)'(q4[c])
                 - (SUM_W+1)'({q4[c], 8'h00});
    assign bump  = (rem >= (SUM_W+1)'(255));
    assign q_fix = {1'b0, q4[c]} + (LIN+1)'(bump);
    always_ff @(posedge clk) begin
      if (en[5]) begin
        lin5[c] <= q_fix[LIN] ? {LIN{1'b1}} : q_fix[LIN-1:0];
      end
    end

    // Encode table index from the top of the linear value
    if (LIN >= ENC) begin : g_idx_shr
      assign eidx5[c] = lin5[c][LIN-1 -: ENC];
    end else begin : g_idx_shl
      assign eidx5[c] = {lin5[c], {(ENC - LIN){1'b0}}};
    end

    // Display encode table; writes land in the same stage as reads
    gac_ram #(.WIDTH(8), .DEPTH(1 << ENC)) u_enc (
      .clk   (clk),
      .we    (en[6] && vld[5] && side[5].enc_we),
      .waddr (side[5].enc_idx),
      .wdata (side[5].enc_val),
      .re    (en[6]),
      .raddr (eidx5[c]),
      .rdata (enc6[c])
    );
  end

  // Select raw background for transparent pixels
  assign out_red   = side[NSTG].transp ? side[NSTG].bg[0] : enc6[0];
  assign out_green = side[NSTG].transp ? side[NSTG].bg[1] : enc6[1];
  assign out_blue  = side[NSTG].transp ? side[NSTG].bg[2] : enc6[2];

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for gamma_alpha_compositor.
// Keeps its own copy of the three lookup tables and predicts every composited pixel.
// Depends on rtl/gac_pkg.sv, rtl/gac_ram.sv and rtl/gamma_alpha_compositor.sv.
`timescale 1ns / 1ps

module tb_top;
  import gac_pkg::*;

  localparam int LIN_W        = LIN_BITS_DEF;
  localparam int ENC_W        = ENC_INDEX_BITS_DEF;
  localparam int ENC_DEPTH    = 1 << ENC_W;
  localparam int STALL_LIMIT  = 2000;  // cycles with no request or pixel moving
  localparam int DRAIN_CYCLES = 20;    // well past the six-stage pipeline
  localparam int PHASE_ITEMS  = 138;

  typedef logic [NUM_CH-1:0][7:0] rgb_t;  // [0] red, [1] green, [2] blue

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  kind_t       req_kind;
  logic [11:0] tbl_idx;
  logic [15:0] tbl_val;
  rgb_t        fg_px;
  logic [7:0]  fg_a;
  rgb_t        bg_px;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  // Shadow tables and the pixels still owed by the block
  logic [LIN_W-1:0] fg_lin [256];
  logic [LIN_W-1:0] bg_lin [256];
  logic [7:0]       enc_code [ENC_DEPTH];
  bit               fg_set [256];
  bit               bg_set [256];
  bit               enc_set [ENC_DEPTH];
  logic [7:0]       fg_codes [$];
  logic [7:0]       bg_codes [$];
  rgb_t             display_q [$];

  int   err_cnt = 0;
  int   req_cnt;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cyc = 0;
  rgb_t got_px;
  rgb_t want_px;

  gamma_alpha_compositor u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (req_kind),
    .table_index (tbl_idx),
    .table_value (tbl_val),
    .fg_red      (fg_px[0]),
    .fg_green    (fg_px[1]),
    .fg_blue     (fg_px[2]),
    .fg_alpha    (fg_a),
    .bg_red      (bg_px[0]),
    .bg_green    (bg_px[1]),
    .bg_blue     (bg_px[2]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Top bits of a linear value select the display code
  function automatic int enc_addr(input logic [LIN_W-1:0] lin);
    return int'(lin >> (LIN_W - ENC_W));
  endfunction

  // Linear blend with round-to-nearest divide by 255
  function automatic logic [LIN_W-1:0] mix_lin(input logic [LIN_W-1:0] lf,
                                               input logic [LIN_W-1:0] lb,
                                               input logic [7:0] a);
    logic [31:0] acc;
    acc = 32'(lf) * 32'(a) + 32'(lb) * (32'd255 - 32'(a)) + 32'd127;
    acc = acc / 32'd255;
    if (acc > {LIN_W{1'b1}}) begin
      acc = {LIN_W{1'b1}};
    end
    return acc[LIN_W-1:0];
  endfunction

  function automatic rgb_t composite_pixel(input rgb_t fg, input logic [7:0] a,
                                           input rgb_t bg);
    rgb_t px;
    for (int c = 0; c < NUM_CH; c++) begin
      if (a == 8'd0) begin
        px[c] = bg[c];
      end else if (a == 8'd255) begin
        px[c] = enc_code[enc_addr(fg_lin[fg[c]])];
      end else begin
        px[c] = enc_code[enc_addr(mix_lin(fg_lin[fg[c]], bg_lin[bg[c]], a))];
      end
    end
    return px;
  endfunction

  function automatic rgb_t rnd_rgb();
    rgb_t rv;
    rv = rgb_t'($urandom);
    return rv;
  endfunction

  // Mostly reuse codes whose decode entry is loaded, sometimes a fresh one
  function automatic logic [7:0] pick_code(input bit from_bg);
    if (!from_bg && fg_codes.size() > 0 && $urandom_range(3) != 0) begin
      return fg_codes[$urandom_range(fg_codes.size() - 1)];
    end
    if (from_bg && bg_codes.size() > 0 && $urandom_range(3) != 0) begin
      return bg_codes[$urandom_range(bg_codes.size() - 1)];
    end
    return 8'($urandom);
  endfunction

  // Update the shadow state, then present one request and hold it until taken
  task automatic send_req(input kind_t k, input logic [11:0] idx,
                          input logic [15:0] val, input rgb_t fg,
                          input logic [7:0] a, input rgb_t bg);
    case (k)
      KIND_FG_WR: begin
        fg_lin[idx[7:0]] = val[LIN_W-1:0];
        if (!fg_set[idx[7:0]]) begin
          fg_set[idx[7:0]] = 1'b1;
          fg_codes.push_back(idx[7:0]);
        end
      end
      KIND_BG_WR: begin
        bg_lin[idx[7:0]] = val[LIN_W-1:0];
        if (!bg_set[idx[7:0]]) begin
          bg_set[idx[7:0]] = 1'b1;
          bg_codes.push_back(idx[7:0]);
        end
      end
      KIND_ENC_WR: begin
        enc_code[idx[ENC_W-1:0]] = val[7:0];
        enc_set[idx[ENC_W-1:0]]  = 1'b1;
      end
      default: begin
        display_q.push_back(composite_pixel(fg, a, bg));
      end
    endcase
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req_kind <= k;
    tbl_idx  <= idx;
    tbl_val  <= val;
    fg_px    <= fg;
    fg_a     <= a;
    bg_px    <= bg;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    req_cnt++;
  endtask

  // Load any table entry this pixel will touch, then send the pixel
  task automatic send_pixel(input rgb_t fg, input logic [7:0] a, input rgb_t bg);
    int ea;
    for (int c = 0; c < NUM_CH; c++) begin
      if (!fg_set[fg[c]]) begin
        send_req(KIND_FG_WR, {4'($urandom), fg[c]}, 16'($urandom), rnd_rgb(),
                 8'($urandom), rnd_rgb());
      end
      if (!bg_set[bg[c]]) begin
        send_req(KIND_BG_WR, {4'($urandom), bg[c]}, 16'($urandom), rnd_rgb(),
                 8'($urandom), rnd_rgb());
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      ea = enc_addr(mix_lin(fg_lin[fg[c]], bg_lin[bg[c]], a));
      if (!enc_set[ea]) begin
        send_req(KIND_ENC_WR, 12'(ea), 16'($urandom), rnd_rgb(), 8'($urandom),
                 rnd_rgb());
      end
    end
    send_req(KIND_PIXEL, 12'($urandom), 16'($urandom), fg, a, bg);
  endtask

  // Extreme addresses and values, with upper index and value bits that must be dropped
  task automatic test_table_writes();
    send_req(KIND_FG_WR, 12'hF00, 16'h0000, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_req(KIND_FG_WR, 12'hFFF, 16'hFFFF, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_req(KIND_BG_WR, 12'h000, 16'hFFFF, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_req(KIND_BG_WR, 12'hAFF, 16'h0000, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_req(KIND_ENC_WR, 12'h000, 16'hFF00, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_req(KIND_ENC_WR, 12'hFFF, 16'h00FF, rnd_rgb(), 8'($urandom), rnd_rgb());
  endtask

  // Transparent, opaque, the blend edges and a mid blend on black and white codes
  task automatic test_alpha_extremes();
    send_pixel({8'd0, 8'd255, 8'd0}, 8'd0, {8'd255, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd0}, 8'd255, {8'd255, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd0}, 8'd1, {8'd255, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd255}, 8'd254, {8'd0, 8'd255, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255}, 8'd128, {8'd0, 8'd0, 8'd0});
  endtask

  // Table writes followed at once by pixels that read the new entries
  task automatic test_write_then_read();
    send_req(KIND_FG_WR, 12'h080, 16'h8000, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_pixel({3{8'h80}}, 8'd255, {3{8'h00}});
    send_req(KIND_ENC_WR, 12'h800, 16'h0055, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_pixel({3{8'h80}}, 8'd255, {3{8'h00}});
    send_req(KIND_FG_WR, 12'h580, 16'h800F, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_pixel({3{8'h80}}, 8'd255, {3{8'hFF}});
    send_req(KIND_BG_WR, 12'h080, 16'h1234, rnd_rgb(), 8'($urandom), rnd_rgb());
    send_pixel({3{8'h80}}, 8'd77, {3{8'h80}});
  endtask

  // Mostly pixels over loaded entries, with stray table rewrites mixed in
  task automatic test_random_traffic(input int idle, input int stall, input int n);
    int   first;
    rgb_t fg;
    rgb_t bg;
    logic [7:0] a;
    first     = req_cnt;
    idle_pct  = idle;
    stall_pct = stall;
    while (req_cnt - first < n) begin
      if ($urandom_range(9) == 0) begin
        send_req(kind_t'($urandom_range(2)), 12'($urandom), 16'($urandom), rnd_rgb(),
                 8'($urandom), rnd_rgb());
      end else begin
        case ($urandom_range(7))
          0:       a = 8'd0;
          1:       a = 8'd255;
          2:       a = $urandom_range(1) ? 8'd1 : 8'd254;
          default: a = 8'($urandom_range(254, 1));
        endcase
        for (int c = 0; c < NUM_CH; c++) begin
          fg[c] = pick_code(1'b0);
          bg[c] = pick_code(1'b1);
        end
        send_pixel(fg, a, bg);
      end
    end
  endtask

  // Randomly stall the output side
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_px = {out_blue, out_green, out_red};
      if (display_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected pixel expected none actual r=%0d g=%0d b=%0d",
                 $time, out_red, out_green, out_blue);
      end else begin
        want_px = display_q.pop_front();
        for (int c = 0; c < NUM_CH; c++) begin
          if (got_px[c] !== want_px[c]) begin
            err_cnt++;
            $display("%0t: %s expected %0d actual %0d", $time,
                     (c == 0) ? "out_red" : (c == 1) ? "out_green" : "out_blue",
                     want_px[c], got_px[c]);
          end
        end
      end
    end
  end

  // Abort when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_LIMIT) begin
      $display("FAIL gamma_alpha_compositor");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    req_kind  = KIND_PIXEL;
    tbl_idx   = '0;
    tbl_val   = '0;
    fg_px     = '0;
    fg_a      = '0;
    bg_px     = '0;
    req_cnt   = 0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_table_writes();
    test_alpha_extremes();
    test_write_then_read();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(51, 0, PHASE_ITEMS);
    test_random_traffic(0, 51, PHASE_ITEMS);
    test_random_traffic(27, 27, PHASE_ITEMS);

    // Drop valid, drain the pipeline, then watch for stray results
    @(negedge clk);
    in_valid <= 1'b0;
    while (display_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS gamma_alpha_compositor");
    end else begin
      $display("FAIL gamma_alpha_compositor");
    end
    $finish;
  end

endmodule
